@@ rtl/prle_pkg.sv @@
`timescale 1ns / 1ps

package prle_pkg;

  // longest run a single count byte may carry
  localparam logic [7:0] MAX_RUN = 8'd255;

  // register index of the only configuration register
  localparam logic REG_PIXEL_BYTES = 1'b0;

  // pixel_bytes value after reset
  localparam logic [2:0] PIXEL_BYTES_RESET = 3'd1;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // sequencer phases in the back part
  localparam logic [1:0] PH_RUN_A = 2'd0;
  localparam logic [1:0] PH_RUN_B = 2'd1;
  localparam logic [1:0] PH_TERM  = 2'd2;

  // one input request
  typedef struct packed {
    logic [31:0] pixel_value;
    logic        row_end;
  } pixel_t;

  // one result request
  typedef struct packed {
    logic [7:0] out_byte;
    logic       row_done;
  } result_t;

  // work for the back part caused by one pixel: an optional closed run,
  // then an optional final run followed by the row terminator
  typedef struct packed {
    logic        emit_a;
    logic [7:0]  count_a;
    logic [31:0] pixel_a;
    logic        emit_b;
    logic [7:0]  count_b;
    logic [31:0] pixel_b;
    logic [2:0]  nbytes;
  } job_t;

  // effective bytes per pixel, 1 to 4
  function automatic logic [2:0] eff_bytes(input logic [2:0] pb);
    logic [2:0] r;
    if (pb == 3'd0) begin
      r = 3'd1;
    end else if (pb > 3'd4) begin
      r = 3'd4;
    end else begin
      r = pb;
    end
    return r;
  endfunction

  // compare mask for the low nb bytes
  function automatic logic [31:0] byte_mask(input logic [2:0] nb);
    logic [31:0] m;
    case (nb)
      3'd1: m = 32'h0000_00FF;
      3'd2: m = 32'h0000_FFFF;
      3'd3: m = 32'h00FF_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

@@ rtl/prle_front.sv @@
`timescale 1ns / 1ps

module prle_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  prle_pkg::pixel_t  pixel,
  input  logic [2:0]        pixel_bytes,
  output logic              job_push,
  output prle_pkg::job_t    job,
  input  logic              job_full
);

  logic [31:0] held_pixel;
  logic [7:0]  run_count;
  logic        run_open;

  logic [2:0]  nb;
  logic [31:0] mask;
  logic        extend;
  logic        accept;

  // classify the incoming pixel against the pending run
  always_comb begin
    nb     = prle_pkg::eff_bytes(pixel_bytes);
    mask   = prle_pkg::byte_mask(nb);
    extend = run_open && ((pixel.pixel_value & mask) == (held_pixel & mask))
             && (run_count < prle_pkg::MAX_RUN);
    accept = push && !job_full;
  end

  assign full = job_full;

  // job built from the classification
  always_comb begin
    job.emit_a  = run_open && !extend;
    job.count_a = run_count;
    job.pixel_a = held_pixel;
    job.emit_b  = pixel.row_end;
    job.count_b = extend ? (run_count + 8'd1) : 8'd1;
    job.pixel_b = extend ? held_pixel : pixel.pixel_value;
    job.nbytes  = nb;
    job_push    = accept && (job.emit_a || job.emit_b);
  end

  // pending run state
  always_ff @(posedge clk) begin
    if (rst) begin
      held_pixel <= '0;
      run_count  <= '0;
      run_open   <= 1'b0;
    end else if (accept) begin
      if (pixel.row_end) begin
        run_open  <= 1'b0;
        run_count <= '0;
        if (!extend) begin
          held_pixel <= pixel.pixel_value;
        end
      end else if (extend) begin
        run_count <= run_count + 8'd1;
      end else begin
        held_pixel <= pixel.pixel_value;
        run_count  <= 8'd1;
        run_open   <= 1'b1;
      end
    end
  end

endmodule

@@ rtl/prle_queue.sv @@
`timescale 1ns / 1ps

module prle_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  prle_pkg::job_t  wr_data,
  output logic            is_full,
  input  logic            rd,
  output prle_pkg::job_t  rd_data,
  output logic            is_empty
);

  localparam int PtrW = (prle_pkg::QUEUE_DEPTH > 1) ? $clog2(prle_pkg::QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(prle_pkg::QUEUE_DEPTH + 1);

  prle_pkg::job_t slots [prle_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] fill;

  assign is_full  = (fill == CntW'(prle_pkg::QUEUE_DEPTH));
  assign is_empty = (fill == '0);
  assign rd_data  = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr && !is_full) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr && !is_full) begin
        wr_ptr <= (wr_ptr == PtrW'(prle_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd && !is_empty) begin
        rd_ptr <= (rd_ptr == PtrW'(prle_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({wr && !is_full, rd && !is_empty})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

@@ rtl/prle_back.sv @@
`timescale 1ns / 1ps

module prle_back (
  input  logic              clk,
  input  logic              rst,
  input  prle_pkg::job_t    job,
  input  logic              job_empty,
  output logic              job_pop,
  output logic              empty,
  input  logic              pop,
  output prle_pkg::result_t result
);

  logic [1:0] phase;
  logic [2:0] pos;
  logic [1:0] phase_next;
  logic [2:0] pos_next;
  logic [1:0] eff_phase;
  logic       wide;
  logic [7:0] run_cnt;
  logic [31:0] run_px;
  logic [2:0] byte_sel;
  logic [7:0] byte_val;
  logic       done_bit;
  logic       last_pos;
  logic       finish;
  logic       advance;
  logic       out_valid;
  prle_pkg::result_t out_reg;

  assign wide    = (job.nbytes == 3'd4);
  assign advance = !job_empty && (!out_valid || pop);

  // pick the byte for the current phase and position
  always_comb begin
    eff_phase = phase;
    if (phase == prle_pkg::PH_RUN_A && !job.emit_a) begin
      eff_phase = prle_pkg::PH_RUN_B;
    end
    run_cnt  = (eff_phase == prle_pkg::PH_RUN_A) ? job.count_a : job.count_b;
    run_px   = (eff_phase == prle_pkg::PH_RUN_A) ? job.pixel_a : job.pixel_b;
    byte_sel = wide ? (pos - 3'd2) : (pos - 3'd1);
    done_bit = 1'b0;
    byte_val = 8'd0;
    last_pos = 1'b0;
    case (eff_phase)
      prle_pkg::PH_RUN_A, prle_pkg::PH_RUN_B: begin
        last_pos = wide ? (pos == 3'd5) : (pos == job.nbytes);
        if (pos == 3'd0) begin
          byte_val = run_cnt;
        end else if (wide && pos == 3'd1) begin
          byte_val = 8'd0;
        end else begin
          byte_val = run_px[8*byte_sel[1:0] +: 8];
        end
      end
      prle_pkg::PH_TERM: begin
        last_pos = wide ? (pos == 3'd1) : (pos == 3'd0);
        done_bit = last_pos;
      end
      default: begin
        last_pos = 1'b1;
      end
    endcase
  end

  // sequencer step
  always_comb begin
    phase_next = phase;
    pos_next   = pos + 3'd1;
    finish     = 1'b0;
    if (last_pos) begin
      pos_next = 3'd0;
      case (eff_phase)
        prle_pkg::PH_RUN_A: begin
          if (job.emit_b) begin
            phase_next = prle_pkg::PH_RUN_B;
          end else begin
            phase_next = prle_pkg::PH_RUN_A;
            finish     = 1'b1;
          end
        end
        prle_pkg::PH_RUN_B: begin
          phase_next = prle_pkg::PH_TERM;
        end
        default: begin
          phase_next = prle_pkg::PH_RUN_A;
          finish     = 1'b1;
        end
      endcase
    end
  end

  assign job_pop = advance && finish;

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= prle_pkg::PH_RUN_A;
      pos   <= '0;
    end else if (advance) begin
      phase <= phase_next;
      pos   <= pos_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_reg.out_byte <= byte_val;
      out_reg.row_done <= done_bit;
    end
  end

  assign empty  = !out_valid;
  assign result = out_reg;

endmodule

@@ rtl/pixel_run_length_encoder.sv @@
`timescale 1ns / 1ps

// channel   direction  handshake            payload
// pixel     in         push / full          pixel_value[31:0], row_end
// result    out        pop / empty          out_byte[7:0], row_done
// config    in         apb psel/penable     pixel_bytes[2:0] at byte address 0
//
// one result byte leaves per cycle while results are popped; a pixel costs 0
// to 14 bytes, at most 6 for a differing 4-byte pixel that does not end a
// row, set by the byte-wide output sequencer. the front takes a pixel per
// cycle while the two-entry job queue has room. full follows the job queue;
// empty drops once a closed run's job passes the queue to the output register.
// reset is synchronous and clears run state, queue and output register.

module pixel_run_length_encoder (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  prle_pkg::pixel_t  pixel,
  input  logic              pop,
  output logic              empty,
  output prle_pkg::result_t result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [2:0]     pixel_bytes;
  logic           job_push;
  logic           job_pop;
  logic           job_full;
  logic           job_empty;
  prle_pkg::job_t job_in;
  prle_pkg::job_t job_out;

  // configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_bytes <= prle_pkg::PIXEL_BYTES_RESET;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == prle_pkg::REG_PIXEL_BYTES) begin
      pixel_bytes <= pwdata[2:0];
    end
  end

  assign prdata = (paddr[2] == prle_pkg::REG_PIXEL_BYTES) ? {29'd0, pixel_bytes} : 32'd0;

  prle_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .pixel       (pixel),
    .pixel_bytes (pixel_bytes),
    .job_push    (job_push),
    .job         (job_in),
    .job_full    (job_full)
  );

  prle_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (job_push),
    .wr_data  (job_in),
    .is_full  (job_full),
    .rd       (job_pop),
    .rd_data  (job_out),
    .is_empty (job_empty)
  );

  prle_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (job_out),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

@@ rtl/prle_checker.sv @@
`timescale 1ns / 1ps

module prle_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              full,
  input  logic              pop,
  input  logic              empty,
  input  prle_pkg::result_t result,
  input  logic              pready
);

  // reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result waiting after reset");

  // reset leaves the input side open
  a_reset_open: assert property (@(posedge clk) rst |=> !full)
    else $error("input full after reset");

  // a row terminator byte is always zero
  a_term_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.row_done) |-> (result.out_byte == 8'd0))
    else $error("row terminator byte not zero");

  // a stalled result request holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("stalled result changed");

  // configuration port never waits
  a_ready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind pixel_run_length_encoder prle_checker u_prle_checker (
  .clk    (clk),
  .rst    (rst),
  .full   (full),
  .pop    (pop),
  .empty  (empty),
  .result (result),
  .pready (pready)
);
